@@ rtl/core/sha256_message_hasher_core_defines.svh @@
// ----------------------------------------------------------------------------
// SHA-256 hasher core assertion macros
// Property wrappers for the port checker of the hasher core.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH

// Clocked property, masked while reset is high
`define SMH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well
`define SMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/smh_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Word types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package smh_pkg;

   typedef logic [31:0] word_type;
   typedef logic [60:0] count_type;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] PAD_LEN_POS = 6'd56;
   localparam logic [5:0] BLOCK_LAST  = 6'd63;
   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [2:0] WORD_LAST   = 3'd7;

   localparam word_type INIT_H [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

@@ rtl/core/sha256_message_hasher_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-stream SHA-256 with padding, length append and digest word output.
// ----------------------------------------------------------------------------
// The core takes one message byte per cycle while it gathers a block. The
// 64th byte of a block starts the compression, which runs one round per
// cycle on a single shared round unit, then folds the working words into
// the chaining words. A transaction with tlast set closes the message:
// the core inserts the marker byte, zero bytes and the eight length bytes
// one per cycle outside compression, compresses once or twice, then
// presents the eight digest words on the result side, one per accepted
// transaction. req_tready is low from the byte that fills a block, or
// from tlast, until the core is back to gathering bytes.

module sha256_message_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FOLD, S_OUT} state_type;

   state_type          state_ff, state_in;
   smh_pkg::word_type  h_ff [0:7];
   smh_pkg::word_type  h_in [0:7];
   smh_pkg::word_type  v_ff [0:7];
   smh_pkg::word_type  v_in [0:7];
   logic [511:0]       blk_ff, blk_in;
   smh_pkg::count_type cnt_ff, cnt_in;
   logic [5:0]         rnd_ff, rnd_in;
   logic               pad_on_ff, pad_on_in;
   logic               mark_ff, mark_in;
   logic               len_on_ff, len_on_in;
   logic [2:0]         len_cnt_ff, len_cnt_in;
   logic [63:0]        len_ff, len_in;
   logic               out_pend_ff, out_pend_in;
   logic [2:0]         idx_ff, idx_in;

   logic               absorb_en;
   logic [7:0]         absorb_byte;
   logic               blk_full;
   smh_pkg::count_type cnt_plus;
   smh_pkg::word_type  wt, w_new, t1, t2;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = h_ff[0];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == smh_pkg::WORD_LAST);

   // byte source: the input stream when idle, generated padding while padding
   always_comb begin
      absorb_en   = 1'b0;
      absorb_byte = 8'h00;
      if (state_ff == S_IDLE) begin
         absorb_en   = req_tvalid && req_tuser;
         absorb_byte = req_tdata;
      end else if (state_ff == S_PAD) begin
         absorb_en = 1'b1;
         if (mark_ff) begin
            absorb_byte = smh_pkg::PAD_MARK;
         end else if (len_on_ff || (cnt_ff[5:0] == smh_pkg::PAD_LEN_POS)) begin
            absorb_byte = len_ff[63:56];
         end
      end
   end

   assign blk_full = absorb_en && (cnt_ff[5:0] == smh_pkg::BLOCK_LAST);
   assign cnt_plus = cnt_ff + 61'(req_tuser);

   // shared round unit; block register word k sits at bits 511-32k
   assign wt    = blk_ff[511:480];
   assign w_new = smh_pkg::small_sigma1(blk_ff[63:32]) + blk_ff[223:192] +
                  smh_pkg::small_sigma0(blk_ff[479:448]) + wt;
   assign t1    = v_ff[7] + smh_pkg::big_sigma1(v_ff[4]) +
                  ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
                  smh_pkg::ROUND_K[rnd_ff] + wt;
   assign t2    = smh_pkg::big_sigma0(v_ff[0]) +
                  ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      v_in        = v_ff;
      blk_in      = blk_ff;
      cnt_in      = cnt_ff;
      rnd_in      = rnd_ff;
      pad_on_in   = pad_on_ff;
      mark_in     = mark_ff;
      len_on_in   = len_on_ff;
      len_cnt_in  = len_cnt_ff;
      len_in      = len_ff;
      out_pend_in = out_pend_ff;
      idx_in      = idx_ff;

      if (absorb_en) begin
         blk_in = {blk_ff[503:0], absorb_byte};
         cnt_in = cnt_ff + 61'd1;
      end
      if (blk_full) begin
         v_in   = h_ff;
         rnd_in = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  pad_on_in   = 1'b1;
                  mark_in     = 1'b1;
                  len_on_in   = 1'b0;
                  len_cnt_in  = '0;
                  out_pend_in = 1'b0;
                  len_in      = {cnt_plus, 3'b000};
               end
               if (blk_full) begin
                  state_in = S_ROUND;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            if (mark_ff) begin
               mark_in = 1'b0;
            end else if (len_on_ff || (cnt_ff[5:0] == smh_pkg::PAD_LEN_POS)) begin
               len_in     = {len_ff[55:0], 8'h00};
               len_on_in  = 1'b1;
               len_cnt_in = len_cnt_ff + 3'd1;
               if (len_cnt_ff == smh_pkg::WORD_LAST) begin
                  out_pend_in = 1'b1;
                  pad_on_in   = 1'b0;
               end
            end
            if (blk_full) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            blk_in  = {blk_ff[479:0], w_new};
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == smh_pkg::ROUND_LAST) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int j = 0; j < 8; j++) begin
               h_in[j] = h_ff[j] + v_ff[j];
            end
            if (out_pend_ff) begin
               out_pend_in = 1'b0;
               idx_in      = '0;
               state_in    = S_OUT;
            end else if (pad_on_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               // rotate so the next digest word lands in h_ff[0]
               for (int j = 0; j < 7; j++) begin
                  h_in[j] = h_ff[j + 1];
               end
               h_in[7] = h_ff[0];
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == smh_pkg::WORD_LAST) begin
                  h_in     = smh_pkg::INIT_H;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         h_ff        <= smh_pkg::INIT_H;
         cnt_ff      <= '0;
         rnd_ff      <= '0;
         pad_on_ff   <= 1'b0;
         mark_ff     <= 1'b0;
         len_on_ff   <= 1'b0;
         len_cnt_ff  <= '0;
         out_pend_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         h_ff        <= h_in;
         cnt_ff      <= cnt_in;
         rnd_ff      <= rnd_in;
         pad_on_ff   <= pad_on_in;
         mark_ff     <= mark_in;
         len_on_ff   <= len_on_in;
         len_cnt_ff  <= len_cnt_in;
         out_pend_ff <= out_pend_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      blk_ff <= blk_in;
      len_ff <= len_in;
   end

endmodule

@@ rtl/core/smh_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the hasher core ports for handshake and digest sequencing slips.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_core_defines.svh"

module smh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,   // [31:0] digest_word
   input logic [2:0]  rsp_tuser,   // [2:0] word_index
   input logic        rsp_tlast    // last_word
);

   `SMH_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled digest transaction changed")

   `SMH_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "input taken while digest is out")

   `SMH_ASSERT(a_last_index, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd7)), "tlast does not match final word index")

   `SMH_ASSERT(a_index_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1), "digest words not in sequence")

   `SMH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_tready && !rsp_tvalid, "core not idle after reset")

endmodule

bind sha256_message_hasher_core smh_checker u_smh_checker (.*);

@@ sim/sha256_message_hasher_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hasher stream checker
// Hashes every accepted request byte on its own, queues the eight digest
// words of each closed message and compares them with the response stream.
// ----------------------------------------------------------------------------

module sha256_message_hasher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] digest_word
   input  logic [2:0]  rsp_tuser,   // [2:0] word_index
   input  logic        rsp_tlast,   // last_word
   output int          fail_count,
   output int          words_pending
);

   typedef struct packed {
      smh_pkg::word_type word;
      logic [2:0]        index;
      logic              last;
   } digest_word_type;

   localparam smh_pkg::word_type HASH_SEED [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam smh_pkg::word_type ROUND_CONST [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   smh_pkg::word_type  chain [8];
   logic [7:0]         block_buf [64];
   smh_pkg::word_type  sched [16];
   smh_pkg::count_type byte_count;
   digest_word_type    expected_words [$];
   int                 mismatches;

   function automatic smh_pkg::word_type rotr(smh_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_block();
      smh_pkg::word_type a, b, c, d, e, f, g, h, t1, t2, wt, x15, x2;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
         end else begin
            x15 = sched[(t - 15) & 15];
            x2  = sched[(t - 2) & 15];
            wt  = sched[t & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                + sched[(t - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
         end
         sched[t & 15] = wt;
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[t] + wt;
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endfunction

   function automatic void absorb_byte(logic [7:0] value);
      block_buf[byte_count[5:0]] = value;
      byte_count = byte_count + 1'b1;
      if (byte_count[5:0] == 6'd0)
         compress_block();
   endfunction

   // pad, append the bit length, queue the digest and start a fresh message
   function automatic void close_message();
      logic [63:0] bit_len;
      bit_len = {byte_count, 3'b000};
      absorb_byte(8'h80);
      while (byte_count[5:0] != 6'd56)
         absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--)
         absorb_byte(bit_len[8*i +: 8]);
      for (int i = 0; i < 8; i++)
         expected_words.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
      chain = HASH_SEED;
      byte_count = '0;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: digest mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      digest_word_type exp_word;
      if (reset) begin
         chain = HASH_SEED;
         byte_count = '0;
         expected_words.delete();
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser)
               absorb_byte(req_tdata);
            if (req_tlast)
               close_message();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %h index %0d last %b with none expected",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_tdata !== exp_word.word || rsp_tuser !== exp_word.index ||
                   rsp_tlast !== exp_word.last)
                  report_mismatch($sformatf("got %h/%0d/%b, want %h/%0d/%b",
                                            rsp_tdata, rsp_tuser, rsp_tlast,
                                            exp_word.word, exp_word.index, exp_word.last));
            end
         end
      end
      fail_count    <= mismatches;
      words_pending <= expected_words.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams directed and random messages, byte by byte with idle items mixed
// in, under bursty input and a stalling response side; the checker hashes
// the same bytes and compares every digest word.
// ----------------------------------------------------------------------------

module tb;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eom;
   } hash_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          words_pending;

   hash_item_type stim_q [$];
   int            payload_count;

   sha256_message_hasher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha256_message_hasher_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic queue_item(logic [7:0] data, logic present, logic eom);
      stim_q.push_back('{data: data, present: present, eom: eom});
      payload_count++;
   endtask

   // random bytes with an occasional idle item; close on the last byte or apart
   task automatic queue_message(int len);
      bit split_close;
      split_close = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         queue_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_close);
      end
      if (split_close)
         queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      hash_item_type item;
      int burst;
      int gap;
      int len;
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      payload_count = 0;

      // empty message, ignored idle items, single-byte extremes, "abc", two bytes, empty
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      queue_item(8'hff, 1'b1, 1'b1);
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b0);
      queue_item(8'h5a, 1'b0, 1'b1);
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'h7f, 1'b1, 1'b1);
      queue_item(8'hff, 1'b0, 1'b1);

      while (payload_count < 480) begin
         if ($urandom_range(0, 9) < 3) begin
            // lengths around the padding and block edges
            case ($urandom_range(0, 7))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               default: len = 128;
            endcase
         end else begin
            len = $urandom_range(0, 24);
         end
         // trim the final message to the item budget
         if (len > 480 - payload_count)
            len = 480 - payload_count;
         queue_message(len);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
               queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      burst = 0;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst--;
         req_tvalid <= 1'b1;
         req_tdata  <= item.data;
         req_tuser  <= item.present;
         req_tlast  <= item.eom;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      // let the pending count catch up with the last transaction
      @(posedge clock);
      wait_cycles = 0;
      while (words_pending != 0 && wait_cycles < 50000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (wait_cycles >= 50000) begin
         $display("[sha256_message_hasher_core] ERROR");
      end else begin
         repeat (400) @(posedge clock);
         if (fail_count == 0 && words_pending == 0)
            $display("[sha256_message_hasher_core] OK");
         else
            $display("[sha256_message_hasher_core] ERROR");
      end
      $finish;
   end

   // response side: random stall modes, plus one long hold to back up the core
   initial begin
      int stall_mode;
      int span;
      int cycle_count;
      bit hold_done;
      rsp_tready = 1'b0;
      cycle_count = 0;
      hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall_mode = $urandom_range(0, 2);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(posedge clock);
            cycle_count++;
            if (!hold_done && cycle_count >= 700) begin
               hold_done = 1'b1;
               rsp_tready <= 1'b0;
               repeat (400) @(posedge clock);
            end
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #5000000;
      $display("[sha256_message_hasher_core] ERROR");
      $finish;
   end

endmodule
